// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define JCD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed: %m");

// Checked at every clock edge, reset included.
`define JCD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed: %m");

`else

`define JCD_ASSERT(name, prop)
`define JCD_ASSERT_ALWAYS(name, prop)

`endif

`endif

// ----- rtl/jcd_pkg.sv -----
`timescale 1ns / 1ps

package jcd_pkg;

  typedef enum logic [3:0] {
    MSG_FIGHT    = 4'd0,
    MSG_REMOTE   = 4'd1,
    MSG_GO_FAST  = 4'd2,
    MSG_REFLECT  = 4'd3,
    MSG_ANALOG_X = 4'd4,
    MSG_ANALOG_Y = 4'd5,
    MSG_ACCEL_X  = 4'd6,
    MSG_ACCEL_Y  = 4'd7,
    MSG_OTHER    = 4'd8
  } msg_type_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_FIGHT_ON   = 3'd1,
    EV_FIGHT_OFF  = 3'd2,
    EV_REMOTE_ON  = 3'd3,
    EV_REMOTE_OFF = 3'd4,
    EV_GO_FAST    = 3'd5,
    EV_REFLECT    = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SETUP = 2'd1,
    S_DIV   = 2'd2,
    S_OUT   = 2'd3
  } state_e;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_X_MINIMUM = 1'b0;
  localparam logic REG_Y_MINIMUM = 1'b1;

  localparam logic [7:0] CENTER_ACCEL     = 8'd127;
  localparam logic [7:0] PERCENT_FULL     = 8'd100;
  localparam logic [7:0] FULL_SCALE       = 8'd255;
  localparam logic [7:0] PERCENT_NEG_FULL = 8'h9C;

  localparam int unsigned DIVIDEND_W = 15;
  localparam int unsigned QUOTIENT_W = 7;
  localparam int unsigned DIV_STEPS  = QUOTIENT_W;

  typedef struct packed {
    logic [3:0] msg_type;
    logic [7:0] raw_value;
  } msg_t;

  typedef struct packed {
    logic [2:0]        event_code;
    logic signed [7:0] x_percent;
    logic signed [7:0] y_percent;
  } res_t;

  typedef struct packed {
    logic [7:0] x_minimum;
    logic [7:0] y_minimum;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [DIVIDEND_W-1:0] times_hundred(input logic [7:0] value);
    times_hundred = DIVIDEND_W'({value, 6'b0}) + DIVIDEND_W'({value, 5'b0})
                  + DIVIDEND_W'({value, 2'b0});
  endfunction

endpackage

// ----- rtl/jcd_stream_if.sv -----
`timescale 1ns / 1ps

interface jcd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/jcd_apb_regs.sv -----
`timescale 1ns / 1ps

module jcd_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jcd_pkg::PADDR_W-1:0]    paddr,
  input  logic [jcd_pkg::PDATA_W-1:0]    pwdata,
  output logic [jcd_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  output jcd_pkg::cfg_t                  cfg_o
);

  logic          wr_en;
  logic          reg_sel;
  jcd_pkg::cfg_t cfg_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      if (reg_sel == jcd_pkg::REG_X_MINIMUM) begin
        cfg_q.x_minimum <= pwdata[7:0];
      end else begin
        cfg_q.y_minimum <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == jcd_pkg::REG_Y_MINIMUM) begin
      prdata = jcd_pkg::PDATA_W'(cfg_q.y_minimum);
    end else begin
      prdata = jcd_pkg::PDATA_W'(cfg_q.x_minimum);
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/jcd_divider.sv -----
`timescale 1ns / 1ps

module jcd_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [jcd_pkg::DIVIDEND_W-1:0]      dividend_i,
  input  logic [7:0]                          divisor_i,
  output logic [jcd_pkg::QUOTIENT_W-1:0]      quotient_o,
  output jcd_pkg::div_status_t                status_o
);

  localparam int unsigned QW = jcd_pkg::QUOTIENT_W;

  // The quotient never exceeds 100, so the upper dividend bits start out
  // below the divisor and only the low bits need a restoring step each.
  logic [7:0]    rem_q;
  logic [QW-1:0] shf_q;
  logic [7:0]    div_q;
  logic [2:0]    cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [8:0]    trial;
  logic [8:0]    trial_sub;
  logic          fits;

  assign trial     = {rem_q, shf_q[QW-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 3'(jcd_pkg::DIV_STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 3'd1;
      if (cnt_q == 3'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[jcd_pkg::DIVIDEND_W-1:QW];
      shf_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[7:0] : trial[7:0];
      shf_q <= {shf_q[QW-2:0], fits};
    end
  end

  assign quotient_o    = shf_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ----- rtl/joystick_command_decoder.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Remote-control message decoder.
// The msg_i channel takes one word per message: a message type and a data
// byte. The res_o channel gives one word per message: an event code and the
// current X and Y drive values in percent. Configuration (the X and Y
// minimum readings) is written over the APB port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Event and unused messages pass from the message register through the setup
// and output states to the result register. Analog and accelerometer messages
// go through a serial divider, which resolves one quotient bit per cycle,
// unless the reading equals the center or lies below both center and minimum.
// One message is processed at a time; the next one is accepted in the cycle
// after the result is loaded into the output register.
// The output register holds its word while the receiver stalls, and a new
// message is still taken meanwhile; it then waits for the register to free.
// Reset clears the mode flags, the axis centers and both drive values, and
// sets both minimum registers to zero.
module joystick_command_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  jcd_stream_if.sink                   msg_i,
  jcd_stream_if.source                 res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jcd_pkg::PADDR_W-1:0]  paddr,
  input  logic [jcd_pkg::PDATA_W-1:0]  pwdata,
  output logic [jcd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  jcd_pkg::cfg_t                       cfg;
  jcd_pkg::state_e                     state_q;
  jcd_pkg::state_e                     state_d;
  jcd_pkg::div_status_t                div_st;
  logic [jcd_pkg::QUOTIENT_W-1:0]      quotient;
  logic [jcd_pkg::DIVIDEND_W-1:0]      dividend;

  logic [3:0]     msg_q;
  logic [7:0]     raw_q;
  logic           fight_q;
  logic           remote_q;
  logic           x_cv_q;
  logic           y_cv_q;
  logic [7:0]     x_center_q;
  logic [7:0]     y_center_q;
  logic [7:0]     x_value_q;
  logic [7:0]     y_value_q;
  logic           use_div_q;
  logic           neg_q;
  logic [7:0]     fixed_q;
  logic           res_valid_q;
  jcd_pkg::res_t  res_q;

  logic           msg_ready;
  logic           div_start;
  logic           load;

  logic           is_scale;
  logic [7:0]     center;
  logic [7:0]     minimum;
  logic           above;
  logic           equal;
  logic           below_min;
  logic [7:0]     diff;
  logic [7:0]     divisor;
  logic           needs_div;
  logic [7:0]     fixed;

  logic [7:0]     q_ext;
  logic [7:0]     scaled;
  logic [7:0]     halved;
  jcd_pkg::event_e ev;
  logic           fight_d;
  logic           remote_d;
  logic [7:0]     x_value_d;
  logic [7:0]     y_value_d;

  jcd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jcd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  always_comb begin
    is_scale = 1'b0;
    center   = jcd_pkg::CENTER_ACCEL;
    minimum  = '0;
    unique case (jcd_pkg::msg_type_e'(msg_q))
      jcd_pkg::MSG_ANALOG_X: begin
        is_scale = 1'b1;
        center   = x_cv_q ? x_center_q : raw_q;
        minimum  = cfg.x_minimum;
      end
      jcd_pkg::MSG_ANALOG_Y: begin
        is_scale = 1'b1;
        center   = y_cv_q ? y_center_q : raw_q;
        minimum  = cfg.y_minimum;
      end
      jcd_pkg::MSG_ACCEL_X, jcd_pkg::MSG_ACCEL_Y: begin
        is_scale = 1'b1;
      end
      default: begin
      end
    endcase
    above     = raw_q > center;
    equal     = raw_q == center;
    below_min = raw_q < minimum;
    diff      = above ? raw_q - center : raw_q - minimum;
    divisor   = above ? jcd_pkg::FULL_SCALE - center : center - minimum;
    dividend  = jcd_pkg::times_hundred(diff);
    needs_div = is_scale && !equal && (above || !below_min);
    fixed     = equal ? 8'd0 : jcd_pkg::PERCENT_NEG_FULL;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jcd_pkg::S_IDLE: begin
        if (msg_i.valid) begin
          state_d = jcd_pkg::S_SETUP;
        end
      end
      jcd_pkg::S_SETUP: begin
        state_d = needs_div ? jcd_pkg::S_DIV : jcd_pkg::S_OUT;
      end
      jcd_pkg::S_DIV: begin
        if (div_st.done) begin
          state_d = jcd_pkg::S_OUT;
        end
      end
      jcd_pkg::S_OUT: begin
        if (load) begin
          state_d = jcd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = jcd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    msg_ready = state_q == jcd_pkg::S_IDLE;
    div_start = (state_q == jcd_pkg::S_SETUP) && needs_div;
    load      = (state_q == jcd_pkg::S_OUT) && (!res_valid_q || res_o.ready);
  end

  always_comb begin
    q_ext     = {1'b0, quotient};
    scaled    = use_div_q ? (neg_q ? q_ext - jcd_pkg::PERCENT_FULL : q_ext) : fixed_q;
    halved    = {scaled[7], scaled[7:1]};
    ev        = jcd_pkg::EV_NONE;
    fight_d   = fight_q;
    remote_d  = remote_q;
    x_value_d = x_value_q;
    y_value_d = y_value_q;
    unique case (jcd_pkg::msg_type_e'(msg_q))
      jcd_pkg::MSG_FIGHT: begin
        fight_d = !fight_q;
        ev      = fight_d ? jcd_pkg::EV_FIGHT_ON : jcd_pkg::EV_FIGHT_OFF;
      end
      jcd_pkg::MSG_REMOTE: begin
        remote_d = !remote_q;
        ev       = remote_d ? jcd_pkg::EV_REMOTE_ON : jcd_pkg::EV_REMOTE_OFF;
      end
      jcd_pkg::MSG_GO_FAST: ev = jcd_pkg::EV_GO_FAST;
      jcd_pkg::MSG_REFLECT: ev = jcd_pkg::EV_REFLECT;
      jcd_pkg::MSG_ANALOG_X: x_value_d = scaled;
      jcd_pkg::MSG_ANALOG_Y: y_value_d = scaled;
      jcd_pkg::MSG_ACCEL_X: x_value_d = halved;
      jcd_pkg::MSG_ACCEL_Y: y_value_d = scaled;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jcd_pkg::S_IDLE;
      fight_q     <= 1'b0;
      remote_q    <= 1'b0;
      x_cv_q      <= 1'b0;
      y_cv_q      <= 1'b0;
      x_center_q  <= '0;
      y_center_q  <= '0;
      x_value_q   <= '0;
      y_value_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == jcd_pkg::S_SETUP) begin
        if (msg_q == jcd_pkg::MSG_ANALOG_X && !x_cv_q) begin
          x_center_q <= raw_q;
          x_cv_q     <= 1'b1;
        end
        if (msg_q == jcd_pkg::MSG_ANALOG_Y && !y_cv_q) begin
          y_center_q <= raw_q;
          y_cv_q     <= 1'b1;
        end
      end
      if (load) begin
        fight_q     <= fight_d;
        remote_q    <= remote_d;
        x_value_q   <= x_value_d;
        y_value_q   <= y_value_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (msg_i.valid && msg_ready) begin
      msg_q <= msg_i.payload.msg_type;
      raw_q <= msg_i.payload.raw_value;
    end
    if (state_q == jcd_pkg::S_SETUP) begin
      use_div_q <= needs_div;
      neg_q     <= !above;
      fixed_q   <= fixed;
    end
    if (load) begin
      res_q.event_code <= ev;
      res_q.x_percent  <= x_value_d;
      res_q.y_percent  <= y_value_d;
    end
  end

  assign msg_i.ready   = msg_ready;
  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  `JCD_ASSERT(a_accept_to_setup, msg_i.valid && msg_i.ready |=> state_q == jcd_pkg::S_SETUP)
  `JCD_ASSERT(a_div_running, state_q == jcd_pkg::S_DIV |-> div_st.busy || div_st.done)
  `JCD_ASSERT(a_result_from_out, $rose(res_valid_q) |-> $past(state_q == jcd_pkg::S_OUT))
  `JCD_ASSERT(a_x_range, res_valid_q |-> ($signed(res_q.x_percent) >= -8'sd100)
              && ($signed(res_q.x_percent) <= 8'sd100))
  `JCD_ASSERT(a_y_range, res_valid_q |-> ($signed(res_q.y_percent) >= -8'sd100)
              && ($signed(res_q.y_percent) <= 8'sd100))
  `JCD_ASSERT_ALWAYS(a_div_exclusive, !(div_st.busy && div_st.done))

endmodule
